// ----- rtl/assert_macros.svh -----
// assertion helper macros for the fan ramp profile block
// every check samples on aclk and is disabled while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tfrp_pkg.sv -----
// shared types, constants and helpers for the trapezoid fan ramp profile block
// no dependencies
package tfrp_pkg;

    localparam int TIME_BITS = 16;                      // duration and elapsed width
    localparam int FRAC_BITS = 10;                      // ramp fraction e*1000/dur < 1024
    localparam int NUM_W     = TIME_BITS + FRAC_BITS;   // e*1000 width
    localparam int CNT_W     = $clog2(FRAC_BITS + 1);
    localparam int SPAN_W    = 10;                      // signed peak - min + 1
    localparam int MAG_W     = 9;                       // |span| up to 256
    localparam int PROD_W    = MAG_W + FRAC_BITS;       // |span| * frac
    localparam int RECIP_W   = 19;
    localparam int RECIP_SH  = 28;
    // ceil(2^28 / 1000), exact floor division for products below 2^18
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(268436);
    localparam int QPROD_W   = PROD_W + RECIP_W;
    localparam int DUTY_W    = 8;
    localparam int CALC_W    = 11;                      // signed duty before saturation
    localparam logic [DUTY_W-1:0] MIN_LEVEL_RST = DUTY_W'(80);

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_RISE = 3'd1,
        PH_HOLD = 3'd2,
        PH_FALL = 3'd3,
        PH_GAP  = 3'd4
    } phase_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL1,
        ST_MUL2,
        ST_COMMIT
    } ctrl_state_t;

    typedef struct packed {
        op_t                 operation;
        logic [DUTY_W-1:0]   peak_level;
        logic [15:0]         rise_ms;
        logic [15:0]         hold_ms;
        logic [15:0]         fall_ms;
        logic [15:0]         gap_ms;
    } in_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0]   duty;
        phase_t              phase_now;
        logic                burst_done;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic div_start;
        logic mul1;
        logic mul2;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_ramp;
        logic div_done;
    } sts_t;

    function automatic logic [DUTY_W-1:0] sat_duty(input logic signed [CALC_W-1:0] v);
        logic [DUTY_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > CALC_W'(255)) begin
            r = '1;
        end else begin
            r = v[DUTY_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/tfrp_div.sv -----
// iterative restoring divider, one quotient bit per cycle
// depends on tfrp_pkg; quotient is known to stay below 2^FRAC_BITS
module tfrp_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [tfrp_pkg::NUM_W-1:0]     num,
    input  logic [tfrp_pkg::TIME_BITS-1:0] den,
    output logic                           done,
    output logic [tfrp_pkg::FRAC_BITS-1:0] quot
);
    import tfrp_pkg::*;

    logic [TIME_BITS-1:0] rem_reg,  rem_next;
    logic [TIME_BITS-1:0] den_reg;
    logic [FRAC_BITS-1:0] sh_reg,   sh_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [TIME_BITS:0]   trial;
    logic                 ge;

    always_comb begin
        trial    = {rem_reg, sh_reg[FRAC_BITS-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? TIME_BITS'(trial - {1'b0, den_reg}) : trial[TIME_BITS-1:0];
        sh_next  = {sh_reg[FRAC_BITS-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(FRAC_BITS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // remainder starts at the high numerator bits, which are below the divisor
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num[NUM_W-1:FRAC_BITS];
            sh_reg  <= num[FRAC_BITS-1:0];
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            sh_reg  <= sh_next;
        end
    end

    assign done = done_reg;
    assign quot = sh_reg;

endmodule

// ----- rtl/tfrp_dp.sv -----
// datapath: burst state, ramp fraction divider, span multiply and /1000 scaling
// depends on tfrp_pkg and tfrp_div
module tfrp_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tfrp_pkg::cmd_t              cmd,
    input  tfrp_pkg::in_item_t          in_item,
    input  logic [tfrp_pkg::DUTY_W-1:0] min_level,
    output tfrp_pkg::sts_t              sts,
    output tfrp_pkg::result_t           result
);
    import tfrp_pkg::*;

    in_item_t              item_reg;
    phase_t                phase_reg,   phase_next;
    logic [TIME_BITS-1:0]  elapsed_reg, elapsed_next;
    logic [DUTY_W-1:0]     peak_reg,    peak_next;
    logic [TIME_BITS-1:0]  rise_reg,    rise_next;
    logic [TIME_BITS-1:0]  hold_reg,    hold_next;
    logic [TIME_BITS-1:0]  fall_reg,    fall_next;
    logic [TIME_BITS-1:0]  gap_reg,     gap_next;
    logic [DUTY_W-1:0]     duty_reg,    duty_next;

    logic [PROD_W-1:0]     mag_reg;
    logic                  neg_reg;
    logic [QPROD_W-1:0]    qprod_reg;

    logic [NUM_W-1:0]      div_num;
    logic [TIME_BITS-1:0]  div_den;
    logic                  div_done;
    logic [FRAC_BITS-1:0]  div_quot;

    logic signed [SPAN_W-1:0] span;
    logic [MAG_W-1:0]         span_mag;
    logic [DUTY_W-1:0]        delta_mag;
    logic signed [CALC_W-1:0] delta;
    logic signed [CALC_W-1:0] duty_calc;
    logic [DUTY_W-1:0]        tick_duty;
    logic [TIME_BITS-1:0]     e_inc;
    logic [TIME_BITS-1:0]     rise_in;
    logic [TIME_BITS-1:0]     fall_in;

    // e*1000 = e*1024 - e*16 - e*8
    assign div_num = {elapsed_reg, FRAC_BITS'(0)}
                   - NUM_W'({elapsed_reg, 4'b0})
                   - NUM_W'({elapsed_reg, 3'b0});
    assign div_den = (phase_reg == PH_RISE) ? rise_reg : fall_reg;

    tfrp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        span     = SPAN_W'($signed({2'b0, peak_reg})) - SPAN_W'($signed({2'b0, min_level}))
                 + SPAN_W'(1);
        span_mag = span[SPAN_W-1] ? MAG_W'(-span) : MAG_W'(span);
    end

    // ramp term, magnitude scaled by 1/1000 then signed
    always_comb begin
        delta_mag = qprod_reg[RECIP_SH +: DUTY_W];
        delta     = neg_reg ? -CALC_W'($signed({1'b0, delta_mag}))
                            :  CALC_W'($signed({1'b0, delta_mag}));
        if (phase_reg == PH_RISE) begin
            duty_calc = CALC_W'($signed({1'b0, min_level})) + delta;
        end else begin
            duty_calc = CALC_W'($signed({1'b0, peak_reg})) - delta;
        end
    end

    assign sts.need_ramp = (item_reg.operation == OP_TICK)
                        && (phase_reg inside {PH_RISE, PH_FALL});
    assign sts.div_done  = div_done;

    assign rise_in = TIME_BITS'(item_reg.rise_ms);
    assign fall_in = TIME_BITS'(item_reg.fall_ms);
    assign e_inc   = elapsed_reg + TIME_BITS'(1);

    // result and next burst state for the latched item
    always_comb begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        peak_next    = peak_reg;
        rise_next    = rise_reg;
        hold_next    = hold_reg;
        fall_next    = fall_reg;
        gap_next     = gap_reg;
        duty_next    = duty_reg;
        tick_duty    = duty_reg;
        result       = '{duty: duty_reg, phase_now: phase_reg, burst_done: 1'b0};

        if (item_reg.operation == OP_START) begin
            if (phase_reg == PH_IDLE) begin
                peak_next    = item_reg.peak_level;
                rise_next    = (rise_in == '0) ? TIME_BITS'(1) : rise_in;
                hold_next    = TIME_BITS'(item_reg.hold_ms);
                fall_next    = (fall_in == '0) ? TIME_BITS'(1) : fall_in;
                gap_next     = TIME_BITS'(item_reg.gap_ms);
                elapsed_next = '0;
                phase_next   = PH_RISE;
                duty_next    = min_level;
                result       = '{duty: min_level, phase_now: PH_RISE, burst_done: 1'b0};
            end
        end else if (phase_reg == PH_IDLE) begin
            result = '{duty: '0, phase_now: PH_IDLE, burst_done: 1'b0};
        end else begin
            case (phase_reg)
                PH_RISE, PH_FALL: tick_duty = sat_duty(duty_calc);
                PH_GAP:           tick_duty = '0;
                default:          tick_duty = duty_reg;
            endcase
            duty_next    = tick_duty;
            result       = '{duty: tick_duty, phase_now: phase_reg, burst_done: 1'b0};
            elapsed_next = e_inc;
            case (phase_reg)
                PH_RISE: begin
                    if (e_inc >= rise_reg) begin
                        elapsed_next = '0;
                        // zero hold is passed over on the same tick
                        phase_next   = (hold_reg == '0) ? PH_FALL : PH_HOLD;
                    end
                end
                PH_HOLD: begin
                    if (e_inc >= hold_reg) begin
                        elapsed_next = '0;
                        phase_next   = PH_FALL;
                    end
                end
                PH_FALL: begin
                    if (e_inc >= fall_reg) begin
                        elapsed_next = '0;
                        duty_next    = '0;
                        if (gap_reg == '0) begin
                            phase_next        = PH_IDLE;
                            result.burst_done = 1'b1;
                        end else begin
                            phase_next = PH_GAP;
                        end
                    end
                end
                PH_GAP: begin
                    if (e_inc >= gap_reg) begin
                        elapsed_next      = '0;
                        duty_next         = '0;
                        phase_next        = PH_IDLE;
                        result.burst_done = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            item_reg <= in_item;
        end
        if (cmd.mul1) begin
            mag_reg <= PROD_W'(span_mag * div_quot);
            neg_reg <= span[SPAN_W-1];
        end
        if (cmd.mul2) begin
            qprod_reg <= QPROD_W'(mag_reg * RECIP_M);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            elapsed_reg <= '0;
            peak_reg    <= '0;
            rise_reg    <= TIME_BITS'(1);
            hold_reg    <= '0;
            fall_reg    <= TIME_BITS'(1);
            gap_reg     <= '0;
            duty_reg    <= '0;
        end else if (cmd.commit) begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            peak_reg    <= peak_next;
            rise_reg    <= rise_next;
            hold_reg    <= hold_next;
            fall_reg    <= fall_next;
            gap_reg     <= gap_next;
            duty_reg    <= duty_next;
        end
    end

endmodule

// ----- rtl/tfrp_ctrl.sv -----
// controller state machine sequencing one transaction through the datapath
// depends on tfrp_pkg
module tfrp_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           out_free,
    input  tfrp_pkg::sts_t sts,
    output tfrp_pkg::cmd_t cmd
);
    import tfrp_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_CHECK;
            ST_CHECK:  state_next = sts.need_ramp ? ST_DIV : ST_COMMIT;
            ST_DIV:    if (sts.div_done) state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_COMMIT;
            ST_COMMIT: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_CHECK:  cmd.div_start = sts.need_ramp;
            ST_MUL1:   cmd.mul1      = 1'b1;
            ST_MUL2:   cmd.mul2      = 1'b1;
            ST_COMMIT: cmd.commit    = out_free;
            default: begin
                cmd      = '0;
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/trapezoid_fan_ramp_profile.sv -----
// top level of the trapezoid fan ramp profile generator: stream ports, apb register
// depends on tfrp_pkg, tfrp_ctrl, tfrp_dp (with tfrp_div) and assert_macros.svh
//
// usage
// - each input transaction is either a one-millisecond tick (s_tuser = 0) or a
//   burst start (s_tuser = 1) carrying peak level and rise/hold/fall/gap times
// - every input transaction yields exactly one output transaction: duty,
//   the phase that produced it, and m_tlast set on the tick that ends the burst
// - min_level sits at apb address 0, reset value 80, read live on every tick
// - a tick in rise or fall runs the 10-step fraction divider and two
//   multiply stages before its result is committed; any other transaction
//   goes from the check straight to commit; the next input is taken in the
//   cycle after that result leaves the datapath, so the block takes no new
//   transaction while one is still in the datapath
// - the result sits in an output register; the block accepts the next input
//   while it waits, and only the final write-back stalls on a busy receiver
// - reset (aresetn low, synchronous) returns to idle with no burst active,
//   duty 0 and empty output register
module trapezoid_fan_ramp_profile (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // peak_level, rise_ms, hold_ms, fall_ms, gap_ms
    input  logic [0:0]  s_tuser,   // operation
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // duty, phase_now, zero fill
    output logic        m_tlast,   // burst_done
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tfrp_pkg::*;

    logic [DUTY_W-1:0] min_level_reg;
    in_item_t          in_item;
    cmd_t              cmd;
    sts_t              sts;
    result_t           result;
    result_t           out_reg;
    logic              m_tvalid_reg;
    logic              out_free;
    logic              cfg_write;

    // apb register file: a single register, word index in paddr[2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == 1'b0) ? {24'b0, min_level_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_level_reg <= MIN_LEVEL_RST;
        end else if (cfg_write && paddr[2] == 1'b0) begin
            min_level_reg <= pwdata[DUTY_W-1:0];
        end
    end

    // unpack the input transaction
    assign in_item.operation  = op_t'(s_tuser[0]);
    assign in_item.peak_level = s_tdata[7:0];
    assign in_item.rise_ms    = s_tdata[23:8];
    assign in_item.hold_ms    = s_tdata[39:24];
    assign in_item.fall_ms    = s_tdata[55:40];
    assign in_item.gap_ms     = s_tdata[71:56];

    // output slot can take a result when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    tfrp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    tfrp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_item   (in_item),
        .min_level (min_level_reg),
        .sts       (sts),
        .result    (result)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, out_reg.phase_now, out_reg.duty};
    assign m_tlast  = out_reg.burst_done;

    `include "assert_macros.svh"

    // a result is only written back into a free output slot
    `ASSERT_IMPLIES(a_commit_free, cmd.commit, out_free, "result committed over a pending one")
    // an idle result always drives the fan off
    `ASSERT_IMPLIES(a_idle_off, m_tvalid && out_reg.phase_now == PH_IDLE, out_reg.duty == '0, "idle result with nonzero duty")
    // the burst can only end out of the fall or the gap
    `ASSERT_IMPLIES(a_done_phase, m_tvalid && m_tlast, out_reg.phase_now == PH_GAP || out_reg.phase_now == PH_FALL, "burst end outside fall or gap")
    // the datapath is never asked to start a divide or commit a result while taking input
    `ASSERT_ALWAYS(a_no_overlap, !(cmd.load_in && (cmd.div_start || cmd.commit)), "input load overlaps work on previous transaction")

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for trapezoid_fan_ramp_profile: stream stimulus, apb writes of min_level
// a scoreboard class predicts duty, phase and burst end for every transaction
// depends on tfrp_pkg and the rtl of the block
`timescale 1ns / 100ps

module testbench;
    import tfrp_pkg::*;

    localparam logic [2:0] ADDR_MIN_LEVEL = 3'd0;

    // predicts the fan profile from accepted transactions and checks the results
    class fan_profile_sb;
        logic [7:0]  min_level;
        phase_t      phase;
        logic [15:0] elapsed_ms;
        logic [7:0]  peak_level;
        logic [15:0] rise_ms;
        logic [15:0] hold_ms;
        logic [15:0] fall_ms;
        logic [15:0] gap_ms;
        logic [7:0]  duty_now;
        result_t     pending_duty[$];
        int          mismatches;
        int          results_seen;
        int          bursts_started;
        int          bursts_done;

        function new();
            min_level      = MIN_LEVEL_RST;
            phase          = PH_IDLE;
            elapsed_ms     = '0;
            peak_level     = '0;
            rise_ms        = 16'd1;
            hold_ms        = '0;
            fall_ms        = 16'd1;
            gap_ms         = '0;
            duty_now       = '0;
            mismatches     = 0;
            results_seen   = 0;
            bursts_started = 0;
            bursts_done    = 0;
        endfunction

        // signed span times the ramp fraction, truncated toward zero
        function longint ramp_offset(logic [15:0] dur);
            longint span;
            longint frac;
            span = longint'(peak_level) - longint'(min_level) + 1;
            frac = (longint'(elapsed_ms) * 1000) / longint'(dur);
            return (span * frac) / 1000;
        endfunction

        function logic [7:0] clamp_duty(longint v);
            if (v < 0)
                return 8'd0;
            if (v > 255)
                return 8'd255;
            return v[7:0];
        endfunction

        function void take_command(op_t op, logic [71:0] data);
            result_t want;
            want.burst_done = 1'b0;
            if (op == OP_START) begin
                if (phase == PH_IDLE) begin
                    peak_level = data[7:0];
                    rise_ms    = data[23:8];
                    hold_ms    = data[39:24];
                    fall_ms    = data[55:40];
                    gap_ms     = data[71:56];
                    if (rise_ms == 16'd0)
                        rise_ms = 16'd1;
                    if (fall_ms == 16'd0)
                        fall_ms = 16'd1;
                    elapsed_ms = '0;
                    phase      = PH_RISE;
                    duty_now   = min_level;
                    bursts_started++;
                end
                want.duty      = duty_now;
                want.phase_now = phase;
            end else if (phase == PH_IDLE) begin
                want.duty      = 8'd0;
                want.phase_now = PH_IDLE;
            end else begin
                case (phase)
                    PH_RISE: duty_now = clamp_duty(longint'(min_level) + ramp_offset(rise_ms));
                    PH_FALL: duty_now = clamp_duty(longint'(peak_level) - ramp_offset(fall_ms));
                    PH_GAP:  duty_now = 8'd0;
                    default: ;
                endcase
                want.duty      = duty_now;
                want.phase_now = phase;
                elapsed_ms++;
                // leave every phase that is used up, zero hold and gap fall through
                while (1'b1) begin
                    if (phase == PH_RISE && elapsed_ms >= rise_ms) begin
                        phase      = PH_HOLD;
                        elapsed_ms = '0;
                    end else if (phase == PH_HOLD && elapsed_ms >= hold_ms) begin
                        phase      = PH_FALL;
                        elapsed_ms = '0;
                    end else if (phase == PH_FALL && elapsed_ms >= fall_ms) begin
                        phase      = PH_GAP;
                        elapsed_ms = '0;
                        duty_now   = 8'd0;
                    end else if (phase == PH_GAP && elapsed_ms >= gap_ms) begin
                        phase           = PH_IDLE;
                        elapsed_ms      = '0;
                        duty_now        = 8'd0;
                        want.burst_done = 1'b1;
                        bursts_done++;
                        break;
                    end else begin
                        break;
                    end
                end
            end
            pending_duty.push_back(want);
        endfunction

        function void flag_result(string what, result_t want, logic [7:0] duty,
                                  logic [2:0] ph, logic done);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t %s: expected duty %0d phase %0d done %0d, got duty %0d phase %0d done %0d",
                         $realtime, what, want.duty, want.phase_now, want.burst_done,
                         duty, ph, done);
        endfunction

        function void match_duty(logic [7:0] duty, logic [2:0] ph, logic done);
            result_t want;
            results_seen++;
            if (pending_duty.size() == 0) begin
                flag_result("result with nothing pending", '0, duty, ph, done);
                return;
            end
            want = pending_duty.pop_front();
            if (duty !== want.duty || ph !== want.phase_now || done !== want.burst_done)
                flag_result("result mismatch", want, duty, ph, done);
        endfunction
    endclass

    // block ports, all inputs known from time zero
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;     // peak_level, rise_ms, hold_ms, fall_ms, gap_ms
    logic [0:0]  s_tuser  = '0;     // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // duty, phase_now, zero fill
    logic        m_tlast;           // burst_done
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    fan_profile_sb ramp_sb = new();

    // idle percentages of the two sides, changed between stimulus sections
    int source_gap_pct = 0;
    int sink_stall_pct = 0;
    int level_writes   = 0;

    trapezoid_fan_ramp_profile uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // result side: check each output transaction, then pick the next ready at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            ramp_sb.match_duty(m_tdata[7:0], m_tdata[10:8], m_tlast);
        m_tready <= aresetn && ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic logic [71:0] noise72();
        return 72'({$urandom, $urandom, $urandom});
    endfunction

    function automatic logic [71:0] pack_start(logic [7:0] peak, logic [15:0] rise,
                                               logic [15:0] hold, logic [15:0] fall,
                                               logic [15:0] gap);
        return {gap, fall, hold, rise, peak};
    endfunction

    // mostly short phases so bursts finish often, a few longer ones
    function automatic logic [15:0] pick_ms();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return 16'($urandom_range(6));
        if (roll < 95)
            return 16'($urandom_range(40, 7));
        return 16'($urandom_range(200, 41));
    endfunction

    function automatic logic [7:0] pick_level();
        int roll;
        roll = $urandom_range(99);
        if (roll < 25)
            return 8'd0;
        if (roll < 50)
            return 8'd255;
        return 8'($urandom);
    endfunction

    // one input transaction with optional leading gap; called right after a rising edge
    task automatic send_item(input op_t op, input logic [71:0] data);
        while ($urandom_range(99) < source_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        ramp_sb.take_command(op, data);
    endtask

    task automatic ticks_until_idle();
        while (ramp_sb.phase != PH_IDLE)
            send_item(OP_TICK, noise72());
    endtask

    // hold the source until every pending result has left, then let the pipe settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (ramp_sb.pending_duty.size() != 0)
            @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    task automatic write_min_level(input logic [7:0] level);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MIN_LEVEL;
        pwdata  <= {24'd0, level};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ramp_sb.min_level = level;
        level_writes++;
    endtask

    // random section: mostly complete bursts with random content, some ignored starts
    // and idle ticks as noise, min_level rewritten every few dozen transactions
    task automatic run_profile_mix(input int src_pct, input int snk_pct, input int count);
        int          counted;
        int          since_write;
        logic [71:0] noise;
        counted        = 0;
        since_write    = 0;
        source_gap_pct = src_pct;
        sink_stall_pct = snk_pct;
        while (counted < count) begin
            noise = noise72();
            if (ramp_sb.phase == PH_IDLE) begin
                if ($urandom_range(99) < 80) begin
                    send_item(OP_START, pack_start(noise[7:0], pick_ms(), pick_ms(),
                                                   pick_ms(), pick_ms()));
                    counted++;
                    since_write++;
                end else begin
                    send_item(OP_TICK, noise);
                end
            end else if ($urandom_range(99) < 8) begin
                // start while busy, fully random fields, must be ignored
                send_item(OP_START, noise);
            end else begin
                send_item(OP_TICK, noise);
                counted++;
                since_write++;
            end
            if (since_write >= 45) begin
                since_write = 0;
                write_min_level(pick_level());
            end
        end
    endtask

    initial begin
        #20_000_000;
        $display("trapezoid_fan_ramp_profile: mismatch");
        $finish;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle tick at reset min_level
        send_item(OP_TICK, '1);
        // zero rise and fall saturate to one, zero hold and gap skipped on the same tick
        send_item(OP_START, pack_start(8'd255, 16'd0, 16'd0, 16'd0, 16'd0));
        ticks_until_idle();
        // peak below min_level, and a start with all ones while busy
        send_item(OP_START, pack_start(8'd0, 16'd3, 16'd1, 16'd2, 16'd1));
        send_item(OP_TICK, '0);
        send_item(OP_START, '1);
        ticks_until_idle();
        // full span ramp from zero with a skipped hold
        write_min_level(8'd0);
        send_item(OP_START, pack_start(8'd255, 16'd4, 16'd0, 16'd3, 16'd2));
        ticks_until_idle();
        send_item(OP_TICK, '0);

        write_min_level(8'd255);
        run_profile_mix(31, 76, 80);
        drain_results();   // source holds off until all results are back
        run_profile_mix(76, 31, 80);
        write_min_level(pick_level());
        run_profile_mix(0, 0, 80);

        // two longer bursts that sweep the ramp fraction through its whole range
        write_min_level(8'd0);
        send_item(OP_START, pack_start(8'd255, 16'd37, 16'd2, 16'd29, 16'd2));
        ticks_until_idle();
        write_min_level(8'd200);
        send_item(OP_START, pack_start(8'd10, 16'd23, 16'd1, 16'd19, 16'd1));
        ticks_until_idle();

        drain_results();
        $display("run covered %0d bursts started and %0d completed, %0d results checked",
                 ramp_sb.bursts_started, ramp_sb.bursts_done, ramp_sb.results_seen);
        $display("min_level written %0d times, %0d mismatches",
                 level_writes, ramp_sb.mismatches);
        if (ramp_sb.mismatches == 0 && ramp_sb.pending_duty.size() == 0) begin
            $display("trapezoid_fan_ramp_profile: match");
        end else begin
            $display("trapezoid_fan_ramp_profile: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/tfrp_pkg.sv
rtl/tfrp_div.sv
rtl/tfrp_dp.sv
rtl/tfrp_ctrl.sv
rtl/trapezoid_fan_ramp_profile.sv
bench/testbench.sv
